### sv/twm_pkg.sv
package twm_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned BIT_DELAY_RST = 100;
  localparam int unsigned STRETCH_TIMEOUT_RST = 2000;

  typedef enum logic [0:0] {
    CFG_BIT_DELAY       = 1'b0,
    CFG_STRETCH_TIMEOUT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    logic       cmd_valid;
    op_e        operation;
    logic [7:0] tx_byte;
    logic       msb_lead;
    logic       last_read;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic scl_pull_low;
    logic sda_pull_low;
    logic ready_res;
    logic done_res;
    logic [7:0] rx_byte;
    logic nack;
    logic stretch_timeout;
  } res_t;

  typedef struct packed {
    logic delay_active;
    logic wait_active;
  } tmr_req_t;

  typedef struct packed {
    logic advance;
    logic timed_out;
  } tmr_rsp_t;

endpackage

### sv/two_wire_master_byte_engine_unit.sv
// a word is taken into the input register, processed into the result register once
//   that is free or being emptied, and its result is offered from there
// throughput: one word per cycle if results drain; each word ticks the sequencer
// all line timing is counted in words, set by the bit delay and stretch timeout
// reset: asynchronous, sequencer idle with both lines released, config at defaults
module two_wire_master_byte_engine_unit #(
  parameter int unsigned DELAY_WIDTH   = 10,
  parameter int unsigned TIMEOUT_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [twm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_valid_i,
  input  logic [1:0]                     operation_i,
  input  logic [7:0]                     tx_byte_i,
  input  logic                           msb_lead_i,
  input  logic                           last_read_i,
  input  logic                           scl_in_i,
  input  logic                           sda_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           scl_pull_low_o,
  output logic                           sda_pull_low_o,
  output logic                           ready_res_o,
  output logic                           done_res_o,
  output logic [7:0]                     rx_byte_o,
  output logic                           nack_o,
  output logic                           stretch_timeout_o
);
  import twm_pkg::*;

  logic     a_valid_q;
  item_t    a_item_q;
  logic     out_valid_q;
  res_t     out_res_q;
  logic     proc_en;
  logic     cfg_we;
  tmr_req_t tmr_req;
  tmr_rsp_t tmr_rsp;
  res_t     seq_res;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // a held word moves on when the result register is free or being emptied
  assign proc_en    = a_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~a_valid_q | proc_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
      if (proc_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_item_q.cmd_valid <= cmd_valid_i;
      a_item_q.operation <= op_e'(operation_i);
      a_item_q.tx_byte   <= tx_byte_i;
      a_item_q.msb_lead  <= msb_lead_i;
      a_item_q.last_read <= last_read_i;
      a_item_q.scl_in    <= scl_in_i;
      a_item_q.sda_in    <= sda_in_i;
    end
    if (proc_en) begin
      out_res_q <= seq_res;
    end
  end

  twm_timer #(
    .DELAY_WIDTH  (DELAY_WIDTH),
    .TIMEOUT_WIDTH(TIMEOUT_WIDTH)
  ) u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_reg_e'(cfg_index_i)),
    .cfg_data_i (cfg_data_i),
    .en_i       (proc_en),
    .req_i      (tmr_req),
    .scl_in_i   (a_item_q.scl_in),
    .rsp_o      (tmr_rsp)
  );

  twm_seq u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (proc_en),
    .item_i(a_item_q),
    .rsp_i (tmr_rsp),
    .req_o (tmr_req),
    .res_o (seq_res)
  );

  assign out_valid_o       = out_valid_q;
  assign scl_pull_low_o    = out_res_q.scl_pull_low;
  assign sda_pull_low_o    = out_res_q.sda_pull_low;
  assign ready_res_o       = out_res_q.ready_res;
  assign done_res_o        = out_res_q.done_res;
  assign rx_byte_o         = out_res_q.rx_byte;
  assign nack_o            = out_res_q.nack;
  assign stretch_timeout_o = out_res_q.stretch_timeout;

`ifndef SYNTHESIS
  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> ready_res_o)
    else $error("command finished without returning idle");

  a_processed_word_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_en |=> out_valid_o)
    else $error("processed word did not reach the result register");
`endif

endmodule

### sv/twm_timer.sv
module twm_timer #(
  parameter int unsigned DELAY_WIDTH   = 10,
  parameter int unsigned TIMEOUT_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  twm_pkg::cfg_reg_e                cfg_index_i,
  input  logic [twm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             en_i,
  input  twm_pkg::tmr_req_t                req_i,
  input  logic                             scl_in_i,
  output twm_pkg::tmr_rsp_t                rsp_o
);
  import twm_pkg::*;

  logic [DELAY_WIDTH-1:0]   bit_delay_q;
  logic [TIMEOUT_WIDTH-1:0] stretch_limit_q;
  logic [DELAY_WIDTH-1:0]   delay_cnt_q, delay_cnt_d;
  logic [TIMEOUT_WIDTH-1:0] stretch_cnt_q, stretch_cnt_d;

  logic [DELAY_WIDTH-1:0]   delay_lim;
  logic [DELAY_WIDTH:0]     delay_inc;
  logic                     delay_done;
  logic [TIMEOUT_WIDTH-1:0] stretch_lim;
  logic [TIMEOUT_WIDTH:0]   stretch_inc;
  logic                     stretch_done;

  // a limit of zero acts as one tick, and the carry bit catches a wrap
  assign delay_lim    = (bit_delay_q == '0) ? DELAY_WIDTH'(1) : bit_delay_q;
  assign delay_inc    = {1'b0, delay_cnt_q} + (DELAY_WIDTH + 1)'(1);
  assign delay_done   = delay_inc >= {1'b0, delay_lim};
  assign stretch_lim  = (stretch_limit_q == '0) ? TIMEOUT_WIDTH'(1) : stretch_limit_q;
  assign stretch_inc  = {1'b0, stretch_cnt_q} + (TIMEOUT_WIDTH + 1)'(1);
  assign stretch_done = stretch_inc >= {1'b0, stretch_lim};

  always_comb begin
    delay_cnt_d   = delay_cnt_q;
    stretch_cnt_d = stretch_cnt_q;
    rsp_o         = '0;
    if (en_i && req_i.delay_active) begin
      rsp_o.advance = delay_done;
      delay_cnt_d   = delay_done ? '0 : delay_inc[DELAY_WIDTH-1:0];
    end
    if (en_i && req_i.wait_active) begin
      if (scl_in_i) begin
        stretch_cnt_d = '0;
        rsp_o.advance = 1'b1;
      end else if (stretch_done) begin
        stretch_cnt_d   = '0;
        rsp_o.advance   = 1'b1;
        rsp_o.timed_out = 1'b1;
      end else begin
        stretch_cnt_d = stretch_inc[TIMEOUT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_delay_q     <= DELAY_WIDTH'(BIT_DELAY_RST);
      stretch_limit_q <= TIMEOUT_WIDTH'(STRETCH_TIMEOUT_RST);
      delay_cnt_q     <= '0;
      stretch_cnt_q   <= '0;
    end else begin
      delay_cnt_q   <= delay_cnt_d;
      stretch_cnt_q <= stretch_cnt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BIT_DELAY: begin
            bit_delay_q <= cfg_data_i[DELAY_WIDTH-1:0];
          end
          CFG_STRETCH_TIMEOUT: begin
            stretch_limit_q <= cfg_data_i[TIMEOUT_WIDTH-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_timeout_only_low_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.timed_out |-> (req_i.wait_active && !scl_in_i && rsp_o.advance))
    else $error("timeout outside a low clock wait");
`endif

endmodule

### sv/twm_seq.sv
module twm_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  twm_pkg::item_t      item_i,
  input  twm_pkg::tmr_rsp_t   rsp_i,
  output twm_pkg::tmr_req_t   req_o,
  output twm_pkg::res_t       res_o
);
  import twm_pkg::*;

  // one state per delay or clock wait of each command
  typedef enum logic [25:0] {
    S_IDLE  = 26'd1 << 0,
    S_ST_D1 = 26'd1 << 1,
    S_ST_W  = 26'd1 << 2,
    S_ST_D2 = 26'd1 << 3,
    S_ST_D3 = 26'd1 << 4,
    S_ST_D4 = 26'd1 << 5,
    S_SP_D1 = 26'd1 << 6,
    S_SP_W  = 26'd1 << 7,
    S_SP_D2 = 26'd1 << 8,
    S_SP_D3 = 26'd1 << 9,
    S_WR_D1 = 26'd1 << 10,
    S_WR_W  = 26'd1 << 11,
    S_WR_D2 = 26'd1 << 12,
    S_WR_D3 = 26'd1 << 13,
    S_AK_D1 = 26'd1 << 14,
    S_AK_W  = 26'd1 << 15,
    S_AK_D2 = 26'd1 << 16,
    S_AK_D3 = 26'd1 << 17,
    S_RD_W  = 26'd1 << 18,
    S_RD_D1 = 26'd1 << 19,
    S_RD_D2 = 26'd1 << 20,
    S_RL_D1 = 26'd1 << 21,
    S_RL_W  = 26'd1 << 22,
    S_RL_D2 = 26'd1 << 23,
    S_RL_D3 = 26'd1 << 24,
    S_RL_D4 = 26'd1 << 25
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] bit_q, bit_d;
  logic [2:0] bit_nxt;
  logic [7:0] shift_q, shift_d;
  logic       msb_q, msb_d;
  logic       last_q, last_d;
  logic       scl_low_q, scl_low_d;
  logic       sda_low_q, sda_low_d;
  logic       nack_q, nack_d;
  logic       to_q, to_d;
  logic       done;

  assign bit_nxt = bit_q + 3'd1;

  always_comb begin
    req_o = '0;
    case (state_q)
      S_ST_W, S_SP_W, S_WR_W, S_AK_W, S_RD_W, S_RL_W: begin
        req_o.wait_active = 1'b1;
      end
      S_IDLE: begin
      end
      default: begin
        req_o.delay_active = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    msb_d     = msb_q;
    last_d    = last_q;
    scl_low_d = scl_low_q;
    sda_low_d = sda_low_q;
    nack_d    = nack_q;
    to_d      = to_q;
    done      = 1'b0;
    if (en_i) begin
      if (rsp_i.timed_out) begin
        to_d = 1'b1;
      end
      if (state_q == S_IDLE) begin
        if (item_i.cmd_valid) begin
          msb_d  = item_i.msb_lead;
          last_d = item_i.last_read;
          to_d   = 1'b0;
          bit_d  = 3'd0;
          case (item_i.operation)
            OP_START: begin
              sda_low_d = 1'b0;
              state_d   = S_ST_D1;
            end
            OP_STOP: begin
              sda_low_d = 1'b1;
              state_d   = S_SP_D1;
            end
            OP_WRITE: begin
              shift_d   = item_i.tx_byte;
              sda_low_d = ~(item_i.msb_lead ? item_i.tx_byte[7] : item_i.tx_byte[0]);
              state_d   = S_WR_D1;
            end
            OP_READ: begin
              shift_d   = 8'd0;
              sda_low_d = 1'b0;
              scl_low_d = 1'b0;
              state_d   = S_RD_W;
            end
            default: begin
            end
          endcase
        end
      end else if (rsp_i.advance) begin
        case (state_q)
          S_ST_D1: begin
            scl_low_d = 1'b0;
            state_d   = S_ST_W;
          end
          S_ST_W: state_d = S_ST_D2;
          S_ST_D2: begin
            sda_low_d = 1'b1;
            state_d   = S_ST_D3;
          end
          S_ST_D3: begin
            scl_low_d = 1'b1;
            state_d   = S_ST_D4;
          end
          S_SP_D1: begin
            scl_low_d = 1'b0;
            state_d   = S_SP_W;
          end
          S_SP_W: state_d = S_SP_D2;
          S_SP_D2: begin
            sda_low_d = 1'b0;
            state_d   = S_SP_D3;
          end
          S_WR_D1: begin
            scl_low_d = 1'b0;
            state_d   = S_WR_W;
          end
          S_WR_W: state_d = S_WR_D2;
          S_WR_D2: begin
            scl_low_d = 1'b1;
            state_d   = S_WR_D3;
          end
          S_WR_D3: begin
            if (bit_q != 3'd7) begin
              bit_d     = bit_nxt;
              sda_low_d = ~(msb_q ? shift_q[~bit_nxt] : shift_q[bit_nxt]);
              state_d   = S_WR_D1;
            end else begin
              // release data for the slave's ack
              bit_d     = 3'd0;
              sda_low_d = 1'b0;
              state_d   = S_AK_D1;
            end
          end
          S_AK_D1: begin
            scl_low_d = 1'b0;
            state_d   = S_AK_W;
          end
          S_AK_W: state_d = S_AK_D2;
          S_AK_D2: begin
            nack_d    = item_i.sda_in;
            scl_low_d = 1'b1;
            state_d   = S_AK_D3;
          end
          S_RD_W: state_d = S_RD_D1;
          S_RD_D1: begin
            shift_d[bit_q] = shift_q[bit_q] | item_i.sda_in;
            scl_low_d      = 1'b1;
            state_d        = S_RD_D2;
          end
          S_RD_D2: begin
            if (bit_q != 3'd7) begin
              bit_d     = bit_nxt;
              scl_low_d = 1'b0;
              state_d   = S_RD_W;
            end else begin
              bit_d     = 3'd0;
              sda_low_d = ~last_q;
              state_d   = S_RL_D1;
            end
          end
          S_RL_D1: begin
            scl_low_d = 1'b0;
            state_d   = S_RL_W;
          end
          S_RL_W: state_d = S_RL_D2;
          S_RL_D2: begin
            scl_low_d = 1'b1;
            state_d   = S_RL_D3;
          end
          S_RL_D3: begin
            sda_low_d = 1'b0;
            state_d   = S_RL_D4;
          end
          S_ST_D4, S_SP_D3, S_AK_D3, S_RL_D4: begin
            done    = 1'b1;
            state_d = S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bit_q     <= 3'd0;
      shift_q   <= 8'd0;
      msb_q     <= 1'b0;
      last_q    <= 1'b0;
      scl_low_q <= 1'b0;
      sda_low_q <= 1'b0;
      nack_q    <= 1'b0;
      to_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      msb_q     <= msb_d;
      last_q    <= last_d;
      scl_low_q <= scl_low_d;
      sda_low_q <= sda_low_d;
      nack_q    <= nack_d;
      to_q      <= to_d;
    end
  end

  always_comb begin
    res_o.scl_pull_low    = scl_low_d;
    res_o.sda_pull_low    = sda_low_d;
    res_o.ready_res       = (state_d == S_IDLE);
    res_o.done_res        = done;
    res_o.rx_byte         = shift_d;
    res_o.nack            = nack_d;
    res_o.stretch_timeout = to_d;
  end

`ifndef SYNTHESIS
  a_wait_scl_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.wait_active |-> !scl_low_q)
    else $error("waiting on the clock line while driving it low");

  a_no_done_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && state_q == S_IDLE) |-> !res_o.done_res)
    else $error("done raised on a tick that started idle");
`endif

endmodule

### dv/twm_tick_checker.sv
module twm_tick_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic                           cfg_index_i,
  input  logic [twm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           cmd_valid_i,
  input  logic [1:0]                     operation_i,
  input  logic [7:0]                     tx_byte_i,
  input  logic                           msb_lead_i,
  input  logic                           last_read_i,
  input  logic                           scl_in_i,
  input  logic                           sda_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           scl_pull_low_i,
  input  logic                           sda_pull_low_i,
  input  logic                           ready_res_i,
  input  logic                           done_res_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           nack_i,
  input  logic                           stretch_timeout_i,
  output int                             fail_cnt_o,
  output int                             pending_o
);
  import twm_pkg::*;

  localparam logic [4:0] PC_IDLE = 5'd31;

  typedef enum logic [3:0] {
    MK_SDA_HI,
    MK_SDA_LO,
    MK_SDA_BIT,
    MK_SDA_LAST,
    MK_SCL_LO,
    MK_SCL_REL,
    MK_SAMPLE_RX,
    MK_SAMPLE_ACK,
    MK_LOOP,
    MK_END,
    MK_WAIT,
    MK_DELAY
  } micro_e;

  logic [9:0]  bit_delay_q;
  logic [15:0] stretch_lim_q;
  logic [4:0]  pc_q;
  op_e         op_q;
  logic [3:0]  bit_q;
  logic [9:0]  delay_cnt_q;
  logic [15:0] stretch_cnt_q;
  logic [7:0]  shift_q;
  logic [1:0]  order_last_q;  // bit0 msb first, bit1 nack on read
  logic [1:0]  drive_q;       // bit0 scl low, bit1 sda low
  logic [1:0]  flags_q;       // bit0 nack, bit1 stretch timeout
  res_t        tick_result_q[$];
  int          mismatch_cnt;
  int          stray_cnt;
  int          word_idx;

  function automatic micro_e fetch_micro(op_e op, logic [4:0] pc);
    micro_e k;
    k = MK_END;
    case (op)
      OP_START: begin
        case (pc)
          5'd0: k = MK_SDA_HI;
          5'd2: k = MK_SCL_REL;
          5'd3: k = MK_WAIT;
          5'd5: k = MK_SDA_LO;
          5'd7: k = MK_SCL_LO;
          5'd1, 5'd4, 5'd6, 5'd8: k = MK_DELAY;
          default: k = MK_END;
        endcase
      end
      OP_STOP: begin
        case (pc)
          5'd0: k = MK_SDA_LO;
          5'd2: k = MK_SCL_REL;
          5'd3: k = MK_WAIT;
          5'd5: k = MK_SDA_HI;
          5'd1, 5'd4, 5'd6: k = MK_DELAY;
          default: k = MK_END;
        endcase
      end
      OP_WRITE: begin
        case (pc)
          5'd0:  k = MK_SDA_BIT;
          5'd2:  k = MK_SCL_REL;
          5'd3:  k = MK_WAIT;
          5'd5:  k = MK_SCL_LO;
          5'd7:  k = MK_LOOP;
          5'd8:  k = MK_SDA_HI;
          5'd10: k = MK_SCL_REL;
          5'd11: k = MK_WAIT;
          5'd13: k = MK_SAMPLE_ACK;
          5'd14: k = MK_SCL_LO;
          5'd1, 5'd4, 5'd6, 5'd9, 5'd12, 5'd15: k = MK_DELAY;
          default: k = MK_END;
        endcase
      end
      default: begin
        case (pc)
          5'd0:  k = MK_SDA_HI;
          5'd1:  k = MK_SCL_REL;
          5'd2:  k = MK_WAIT;
          5'd4:  k = MK_SAMPLE_RX;
          5'd5:  k = MK_SCL_LO;
          5'd7:  k = MK_LOOP;
          5'd8:  k = MK_SDA_LAST;
          5'd10: k = MK_SCL_REL;
          5'd11: k = MK_WAIT;
          5'd13: k = MK_SCL_LO;
          5'd15: k = MK_SDA_HI;
          5'd3, 5'd6, 5'd9, 5'd12, 5'd14, 5'd16: k = MK_DELAY;
          default: k = MK_END;
        endcase
      end
    endcase
    return k;
  endfunction

  // runs zero-time micro steps up to the next delay or wait, 1 when the command ends
  function automatic logic run_until_wait(logic sda);
    micro_e     k;
    logic [2:0] b;
    logic       jump;
    int         g;
    for (g = 0; g < 64; g++) begin
      k = fetch_micro(op_q, pc_q);
      b = bit_q[2:0];
      jump = 1'b0;
      case (k)
        MK_SDA_HI:     drive_q[1] = 1'b0;
        MK_SDA_LO:     drive_q[1] = 1'b1;
        MK_SDA_BIT:    drive_q[1] = order_last_q[0] ? ~shift_q[3'd7 - b] : ~shift_q[b];
        MK_SDA_LAST:   drive_q[1] = ~order_last_q[1];
        MK_SCL_LO:     drive_q[0] = 1'b1;
        MK_SCL_REL:    drive_q[0] = 1'b0;
        MK_SAMPLE_RX:  shift_q[b] = shift_q[b] | sda;
        MK_SAMPLE_ACK: flags_q[0] = sda;
        MK_LOOP: begin
          if (b < 3'd7) begin
            bit_q = {1'b0, b} + 4'd1;
            pc_q = (op_q == OP_READ) ? 5'd1 : 5'd0;
            jump = 1'b1;
          end else begin
            bit_q = 4'd0;
          end
        end
        MK_END: begin
          pc_q = PC_IDLE;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
      if (!jump) pc_q = pc_q + 5'd1;
    end
    return 1'b0;
  endfunction

  function automatic res_t advance_tick(item_t it);
    res_t        r;
    logic        fin;
    logic        adv;
    logic [9:0]  dlim;
    logic [15:0] slim;
    micro_e      k;
    fin = 1'b0;
    adv = 1'b0;
    dlim = (bit_delay_q == '0) ? 10'd1 : bit_delay_q;
    slim = (stretch_lim_q == '0) ? 16'd1 : stretch_lim_q;
    if (pc_q == PC_IDLE) begin
      if (it.cmd_valid) begin
        op_q = it.operation;
        if (it.operation == OP_WRITE) shift_q = it.tx_byte;
        else if (it.operation == OP_READ) shift_q = 8'h00;
        order_last_q = {it.last_read, it.msb_lead};
        flags_q[1] = 1'b0;
        bit_q = '0;
        delay_cnt_q = '0;
        stretch_cnt_q = '0;
        pc_q = 5'd0;
        fin = run_until_wait(it.sda_in);
      end
    end else begin
      k = fetch_micro(op_q, pc_q);
      if (k == MK_DELAY) begin
        delay_cnt_q = delay_cnt_q + 10'd1;
        if (delay_cnt_q >= dlim || delay_cnt_q == '0) begin
          delay_cnt_q = '0;
          adv = 1'b1;
        end
      end else if (k == MK_WAIT) begin
        if (it.scl_in) begin
          stretch_cnt_q = '0;
          adv = 1'b1;
        end else begin
          stretch_cnt_q = stretch_cnt_q + 16'd1;
          if (stretch_cnt_q >= slim || stretch_cnt_q == '0) begin
            stretch_cnt_q = '0;
            flags_q[1] = 1'b1;
            adv = 1'b1;
          end
        end
      end else begin
        // should not sit on an instant step; rerun it
        pc_q = pc_q - 5'd1;
        adv = 1'b1;
      end
      if (adv) begin
        pc_q = pc_q + 5'd1;
        fin = run_until_wait(it.sda_in);
      end
    end
    r.scl_pull_low    = drive_q[0];
    r.sda_pull_low    = drive_q[1];
    r.ready_res       = (pc_q == PC_IDLE);
    r.done_res        = fin;
    r.rx_byte         = shift_q;
    r.nack            = flags_q[0];
    r.stretch_timeout = flags_q[1];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    item_t it;
    res_t  got;
    res_t  want;
    if (!rst_ni) begin
      bit_delay_q   = 10'(BIT_DELAY_RST);
      stretch_lim_q = 16'(STRETCH_TIMEOUT_RST);
      pc_q          = PC_IDLE;
      op_q          = OP_START;
      bit_q         = '0;
      delay_cnt_q   = '0;
      stretch_cnt_q = '0;
      shift_q       = '0;
      order_last_q  = '0;
      drive_q       = '0;
      flags_q       = '0;
      tick_result_q.delete();
      mismatch_cnt  = 0;
      stray_cnt     = 0;
      word_idx      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_BIT_DELAY) bit_delay_q = cfg_data_i[9:0];
        else stretch_lim_q = cfg_data_i[15:0];
      end
      if (in_valid_i && in_ready_i) begin
        it.cmd_valid = cmd_valid_i;
        it.operation = op_e'(operation_i);
        it.tx_byte   = tx_byte_i;
        it.msb_lead  = msb_lead_i;
        it.last_read = last_read_i;
        it.scl_in    = scl_in_i;
        it.sda_in    = sda_in_i;
        tick_result_q.push_back(advance_tick(it));
      end
      if (out_valid_i && out_ready_i) begin
        got.scl_pull_low    = scl_pull_low_i;
        got.sda_pull_low    = sda_pull_low_i;
        got.ready_res       = ready_res_i;
        got.done_res        = done_res_i;
        got.rx_byte         = rx_byte_i;
        got.nack            = nack_i;
        got.stretch_timeout = stretch_timeout_i;
        if (tick_result_q.size() == 0) begin
          stray_cnt++;
          if (mismatch_cnt + stray_cnt <= 10)
            $display("word %0d: result with nothing expected", word_idx);
        end else begin
          want = tick_result_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt + stray_cnt <= 10)
              $display("word %0d: exp scl %b sda %b rdy %b done %b rx %h nack %b to %b",
                       word_idx, want.scl_pull_low, want.sda_pull_low, want.ready_res,
                       want.done_res, want.rx_byte, want.nack, want.stretch_timeout,
                       " / got scl %b sda %b rdy %b done %b rx %h nack %b to %b",
                       got.scl_pull_low, got.sda_pull_low, got.ready_res,
                       got.done_res, got.rx_byte, got.nack, got.stretch_timeout);
          end
        end
        word_idx++;
      end
    end
    fail_cnt_o = mismatch_cnt + stray_cnt;
    pending_o  = tick_result_q.size();
  end

endmodule

### dv/tb_two_wire_master_byte_engine_unit.sv
module tb_two_wire_master_byte_engine_unit;
  import twm_pkg::*;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_index_i = CFG_BIT_DELAY;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  cmd_valid_i = 1'b0;
  logic [1:0]            operation_i = OP_START;
  logic [7:0]            tx_byte_i   = '0;
  logic                  msb_lead_i  = 1'b0;
  logic                  last_read_i = 1'b0;
  logic                  scl_in_i    = 1'b1;
  logic                  sda_in_i    = 1'b1;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  scl_pull_low_o;
  logic                  sda_pull_low_o;
  logic                  ready_res_o;
  logic                  done_res_o;
  logic [7:0]            rx_byte_o;
  logic                  nack_o;
  logic                  stretch_timeout_o;

  int fail_cnt;
  int pending_cnt;
  int sent_cnt     = 0;
  int rcv_cnt      = 0;
  int last_rdy_idx = -1;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int scl_low_pct  = 0;
  int noise_pct    = 0;

  two_wire_master_byte_engine_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_valid_i       (cmd_valid_i),
    .operation_i       (operation_i),
    .tx_byte_i         (tx_byte_i),
    .msb_lead_i        (msb_lead_i),
    .last_read_i       (last_read_i),
    .scl_in_i          (scl_in_i),
    .sda_in_i          (sda_in_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .scl_pull_low_o    (scl_pull_low_o),
    .sda_pull_low_o    (sda_pull_low_o),
    .ready_res_o       (ready_res_o),
    .done_res_o        (done_res_o),
    .rx_byte_o         (rx_byte_o),
    .nack_o            (nack_o),
    .stretch_timeout_o (stretch_timeout_o)
  );

  twm_tick_checker u_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .cmd_valid_i       (cmd_valid_i),
    .operation_i       (operation_i),
    .tx_byte_i         (tx_byte_i),
    .msb_lead_i        (msb_lead_i),
    .last_read_i       (last_read_i),
    .scl_in_i          (scl_in_i),
    .sda_in_i          (sda_in_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .scl_pull_low_i    (scl_pull_low_o),
    .sda_pull_low_i    (sda_pull_low_o),
    .ready_res_i       (ready_res_o),
    .done_res_i        (done_res_o),
    .rx_byte_i         (rx_byte_o),
    .nack_i            (nack_o),
    .stretch_timeout_i (stretch_timeout_o),
    .fail_cnt_o        (fail_cnt),
    .pending_o         (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("tb_two_wire_master_byte_engine_unit: errors");
    $finish;
  end

  // result side: random stalls, and track the newest word that reported idle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ready_res_o) last_rdy_idx <= rcv_cnt;
      rcv_cnt <= rcv_cnt + 1;
    end
  end

  task automatic send_tick(input logic cv, input op_e op, input logic [7:0] tx,
                           input logic msb, input logic lst);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i  <= 1'b1;
    cmd_valid_i <= cv;
    operation_i <= op;
    tx_byte_i   <= tx;
    msb_lead_i  <= msb;
    last_read_i <= lst;
    scl_in_i    <= ($urandom_range(99) >= scl_low_pct);
    sda_in_i    <= 1'($urandom_range(1));
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
  endtask

  // a bus tick with no intended command; noise_pct of them offer a stray one
  task automatic idle_tick();
    send_tick($urandom_range(99) < noise_pct, op_e'($urandom_range(3)),
              8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic wait_done(input int n);
    while (last_rdy_idx <= n) idle_tick();
  endtask

  task automatic run_cmd(input op_e op, input logic [7:0] tx, input logic msb,
                         input logic lst);
    int n;
    n = sent_cnt;
    send_tick(1'b1, op, tx, msb, lst);
    wait_done(n);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (rcv_cnt != sent_cnt) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reconfig(input logic [CFG_DATA_W-1:0] dly, input logic [CFG_DATA_W-1:0] tmo);
    settle();
    write_reg(CFG_BIT_DELAY, dly);
    write_reg(CFG_STRETCH_TIMEOUT, tmo);
  endtask

  task automatic run_transaction();
    run_cmd(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
            1'($urandom_range(1)));
    if ($urandom_range(1))
      run_cmd(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
    else
      run_cmd(OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
    run_cmd(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)),
            1'($urandom_range(1)));
  endtask

  task automatic run_phase(input int budget);
    int stop_at;
    stop_at = sent_cnt + budget;
    while (sent_cnt < stop_at) begin
      if ($urandom_range(99) < 50) begin
        run_transaction();
      end else if ($urandom_range(1)) begin
        run_cmd(op_e'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
      end else begin
        // raw words with commands offered at random, busy or not
        repeat ($urandom_range(6, 1))
          send_tick(1'($urandom_range(1)), op_e'($urandom_range(3)),
                    8'($urandom_range(255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // power-on settings: one start at the default bit delay
    repeat (3) idle_tick();
    n = sent_cnt;
    send_tick(1'b1, OP_START, 8'h00, 1'b0, 1'b0);
    repeat (30) idle_tick();
    // shorter delay lands while the start is still running
    reconfig(32'd1, 32'd3);
    wait_done(n);

    scl_low_pct = 25;
    run_cmd(OP_WRITE, 8'hA5, 1'b1, 1'b0);
    run_cmd(OP_WRITE, 8'h5A, 1'b0, 1'b0);
    run_cmd(OP_READ, 8'hFF, 1'b1, 1'b0);
    run_cmd(OP_READ, 8'h00, 1'b0, 1'b1);
    run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0);

    // command offered while busy is dropped
    n = sent_cnt;
    send_tick(1'b1, OP_WRITE, 8'h3C, 1'b1, 1'b0);
    idle_tick();
    idle_tick();
    send_tick(1'b1, OP_READ, 8'hC3, 1'b0, 1'b1);
    wait_done(n);

    // clock held low until the stretch wait gives up
    reconfig(32'd1, 32'd4);
    scl_low_pct = 100;
    run_cmd(OP_START, 8'h00, 1'b0, 1'b0);
    scl_low_pct = 25;
    run_cmd(OP_STOP, 8'h00, 1'b0, 1'b0);

    // zero in either register counts as one
    reconfig(32'd0, 32'd0);
    run_cmd(OP_WRITE, 8'h81, 1'b0, 1'b0);

    noise_pct = 3;
    reconfig(32'd1, 32'd3);
    run_phase(30);

    reconfig(32'd2, 32'd1);
    idle_pct = 69;
    run_phase(30);

    reconfig(32'd0, 32'd0);
    idle_pct  = 0;
    stall_pct = 69;
    run_phase(30);

    // upper bits of the write data are beyond the register width
    reconfig(($urandom() | 32'h8000_0000) & ~32'h0000_03FF | 32'd1,
             ($urandom() | 32'h8000_0000) & ~32'h0000_FFFF | 32'd5);
    idle_pct  = 36;
    stall_pct = 36;
    run_phase(30);

    // widest settings, then cut short while the first delay runs
    idle_pct    = 0;
    stall_pct   = 0;
    noise_pct   = 0;
    scl_low_pct = 0;
    reconfig(32'd1023, 32'd65535);
    n = sent_cnt;
    send_tick(1'b1, OP_START, 8'h00, 1'b0, 1'b0);
    repeat (20) idle_tick();
    reconfig(32'd1, 32'd2);
    wait_done(n);

    settle();
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("tb_two_wire_master_byte_engine_unit: clean");
    end else begin
      $display("tb_two_wire_master_byte_engine_unit: errors");
    end
    $finish;
  end

endmodule
